// File: src/decimal_group_slot_layout_unit_assert.svh
// assertion macros shared by the grouped decimal slot layout rtl
`ifndef DECIMAL_GROUP_SLOT_LAYOUT_UNIT_ASSERT_SVH
`define DECIMAL_GROUP_SLOT_LAYOUT_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk and muted during rst
`define DGSL_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked on clk and muted during rst
`define DGSL_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: src/dgsl_pkg.sv
// shared types and constants of the grouped decimal slot layout unit
package dgsl_pkg;

  localparam int VALUE_W      = 64;
  localparam int SLOT_CNT_W   = 5;
  localparam int IDX_W        = 4;
  localparam int KIND_W       = 2;
  localparam int CODE_W       = 8;
  localparam int DIGIT_W      = 4;
  localparam int GROUP_DIGITS = 3;
  localparam int GROUP_W      = GROUP_DIGITS * DIGIT_W;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RST    = 5'd7;
  localparam logic [CODE_W-1:0]     CURRENCY_CODE_RST = 8'd0;
  localparam logic [DIGIT_W-1:0]    BLANK_DIGIT       = 4'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_EMPTY    = 2'd0,
    KIND_CURRENCY = 2'd1,
    KIND_GROUP    = 2'd2
  } slot_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT = 1'b0,
    REG_CURRENCY   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

// File: src/dgsl_ifs.sv
// valid/ready channel interfaces for the input value and the slot results
interface dgsl_in_if import dgsl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface dgsl_out_if import dgsl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   slot_index;
  logic [KIND_W-1:0]  slot_kind;
  logic [CODE_W-1:0]  currency_glyph;
  logic [DIGIT_W-1:0] digit_high;
  logic [DIGIT_W-1:0] digit_mid;
  logic [DIGIT_W-1:0] digit_low;
  logic               last;

  modport source(output valid, output slot_index, output slot_kind, output currency_glyph,
                 output digit_high, output digit_mid, output digit_low, output last,
                 input ready);
  modport sink(input valid, input slot_index, input slot_kind, input currency_glyph,
               input digit_high, input digit_mid, input digit_low, input last,
               output ready);
endinterface

// File: src/dgsl_bcd_conv.sv
// iterative binary to bcd converter, one shift-add-3 step per cycle
module dgsl_bcd_conv import dgsl_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int DIG_COUNT   = 21
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [VALUE_WIDTH-1:0]         value,
  output conv_stat_t                     stat,
  output logic [DIG_COUNT*DIGIT_W-1:0]   digits
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int BCD_W = DIG_COUNT * DIGIT_W;

  logic [VALUE_WIDTH-1:0] shreg;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       adj;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic                   done;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIG_COUNT; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // step counter and status
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift the value msb first into the bcd word
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      bcd   <= '0;
    end else if (busy) begin
      bcd   <= {adj[BCD_W-2:0], shreg[VALUE_WIDTH-1]};
      shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign digits    = bcd;

endmodule

// File: src/decimal_group_slot_layout_unit.sv
// top level: grouped decimal conversion and per-slot display layout
//
//  channel   dir  handshake          payload
//  in_ch     in   valid / ready      value
//  out_ch    out  valid / ready      slot_index slot_kind currency_glyph digit_* last
//  cfg       in   cfg_we (no wait)   cfg_index cfg_wdata
//
// one value goes through the shift-add-3 converter, then a group scan from the top,
// then a walk of one display slot per cycle while out_ch accepts; the converter loop
// sets the bulk. reset is synchronous; no clearing pass. a stalled out_ch holds the
// slot walk; in_ch is ready only while no item is in progress.
`include "decimal_group_slot_layout_unit_assert.svh"

module decimal_group_slot_layout_unit import dgsl_pkg::*; #(
  parameter int MAX_SLOTS   = 16,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  dgsl_in_if.sink               in_ch,
  dgsl_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NGRP       = (DEC_DIGITS + GROUP_DIGITS - 1) / GROUP_DIGITS;
  localparam int DIG_COUNT  = NGRP * GROUP_DIGITS;
  localparam int GSEL_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int GCNT_W     = $clog2(NGRP + 1);

  state_t state;
  state_t state_next;

  logic [SLOT_CNT_W-1:0] slot_count;
  logic [CODE_W-1:0]     currency_code;
  logic [SLOT_CNT_W-1:0] slots;

  conv_stat_t                     conv_st;
  logic [DIG_COUNT*DIGIT_W-1:0]   bcd;
  logic [GROUP_W-1:0]             grp_arr [NGRP];
  logic [GSEL_W-1:0]              gsel;
  logic [GROUP_W-1:0]             grp_rd;

  logic [GSEL_W-1:0]     scan_g;
  logic [GCNT_W-1:0]     groups;
  logic [SLOT_CNT_W-1:0] slot_ctr;
  logic                  scan_hit;

  logic                  in_ready;
  logic                  conv_start;
  logic                  load;

  logic [SLOT_CNT_W-1:0] g_slot;
  int                    sep_i;
  logic                  fits;
  logic                  in_top;
  logic                  shown;
  logic                  last_slot;
  slot_kind_t            kind;
  logic [CODE_W-1:0]     glyph;
  logic [DIGIT_W-1:0]    dh, dm, dl;

  logic                  ovalid;
  logic [IDX_W-1:0]      o_idx;
  slot_kind_t            o_kind;
  logic [CODE_W-1:0]     o_glyph;
  logic [DIGIT_W-1:0]    o_dh, o_dm, o_dl;
  logic                  o_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= SLOT_COUNT_RST;
      currency_code <= CURRENCY_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLOT_COUNT: slot_count    <= cfg_wdata[SLOT_CNT_W-1:0];
        REG_CURRENCY:   currency_code <= cfg_wdata;
      endcase
    end
  end

  // slot count saturates at the build limit
  assign slots = (int'(slot_count) > MAX_SLOTS) ? SLOT_CNT_W'(MAX_SLOTS) : slot_count;

  // single shift-add-3 converter
  dgsl_bcd_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIG_COUNT   (DIG_COUNT)
  ) u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .value  (in_ch.value[VALUE_WIDTH-1:0]),
    .stat   (conv_st),
    .digits (bcd)
  );

  // three-digit groups, least significant first
  for (genvar gi = 0; gi < NGRP; gi++) begin : g_grp
    assign grp_arr[gi] = bcd[gi*GROUP_W +: GROUP_W];
  end

  // group select: top-down scan, then the group of the current slot
  assign g_slot = slots - SLOT_CNT_W'(1) - slot_ctr;
  always_comb begin
    if (state == ST_SCAN) begin
      gsel = scan_g;
    end else if (int'(g_slot) < NGRP) begin
      gsel = g_slot[GSEL_W-1:0];
    end else begin
      gsel = '0;
    end
  end
  assign grp_rd   = grp_arr[gsel];
  assign scan_hit = (grp_rd != '0) || (scan_g == '0);

  // slot layout for the current slot
  assign fits      = (int'(groups) + 1) <= int'(slots);
  assign sep_i     = int'(slots) - int'(groups) - 1;
  assign shown     = int'(g_slot) < int'(groups);
  assign in_top    = int'(g_slot) == (int'(groups) - 1);
  assign last_slot = int'(slot_ctr) == (int'(slots) - 1);

  always_comb begin
    kind  = KIND_GROUP;
    glyph = '0;
    dh    = BLANK_DIGIT;
    dm    = BLANK_DIGIT;
    dl    = BLANK_DIGIT;
    if (fits && (int'(slot_ctr) < sep_i)) begin
      kind = KIND_EMPTY;
    end else if (fits && (int'(slot_ctr) == sep_i)) begin
      kind  = KIND_CURRENCY;
      glyph = currency_code;
    end else if (shown) begin
      // leading zeros of the top group are blank, the units digit never is
      dh = (in_top && grp_rd[11:8] == 4'd0) ? BLANK_DIGIT : grp_rd[11:8];
      dm = (in_top && grp_rd[11:8] == 4'd0 && grp_rd[7:4] == 4'd0) ?
           BLANK_DIGIT : grp_rd[7:4];
      dl = grp_rd[3:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_ch.valid) begin
        state_next = ST_CONV;
      end
      ST_CONV: if (conv_st.done) begin
        state_next = ST_SCAN;
      end
      ST_SCAN: if (scan_hit) begin
        state_next = (slots == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: if (load && last_slot) begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    conv_start = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        conv_start = in_ch.valid;
      end
      ST_CONV: ;
      ST_SCAN: ;
      ST_EMIT: load = !ovalid || out_ch.ready;
    endcase
  end

  assign in_ch.ready = in_ready;

  // group scan and slot walk
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_g   <= '0;
      groups   <= '0;
      slot_ctr <= '0;
    end else begin
      if (conv_st.done) begin
        scan_g <= GSEL_W'(NGRP - 1);
      end else if (state == ST_SCAN && !scan_hit) begin
        scan_g <= scan_g - GSEL_W'(1);
      end
      if (state == ST_SCAN && scan_hit) begin
        groups   <= GCNT_W'({1'b0, scan_g}) + GCNT_W'(1);
        slot_ctr <= '0;
      end else if (load) begin
        slot_ctr <= slot_ctr + SLOT_CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (load) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_idx   <= slot_ctr[IDX_W-1:0];
      o_kind  <= kind;
      o_glyph <= glyph;
      o_dh    <= dh;
      o_dm    <= dm;
      o_dl    <= dl;
      o_last  <= last_slot;
    end
  end

  assign out_ch.valid          = ovalid;
  assign out_ch.slot_index     = o_idx;
  assign out_ch.slot_kind      = KIND_W'(o_kind);
  assign out_ch.currency_glyph = o_glyph;
  assign out_ch.digit_high     = o_dh;
  assign out_ch.digit_mid      = o_dm;
  assign out_ch.digit_low      = o_dl;
  assign out_ch.last           = o_last;

  // checks
  `DGSL_ASSERT_IMP(a_done_in_conv, conv_st.done, state == ST_CONV && !conv_st.busy, "converter finished outside conversion")
  `DGSL_ASSERT_IMP(a_emit_in_range, state == ST_EMIT, slot_ctr < slots && groups != '0, "slot walk out of range")
  `DGSL_ASSERT_NXT(a_last_closes, load && last_slot, ovalid && o_last && state == ST_IDLE, "final slot not closing the item")
  `DGSL_ASSERT_IMP(a_last_index, ovalid && o_last, int'(o_idx) == ((int'(slots) - 1) % 16), "final slot index mismatch")

endmodule

// File: sim/decimal_group_slot_layout_unit_tb.sv
// testbench for the grouped decimal slot layout unit: random and directed amounts, scoreboard
module decimal_group_slot_layout_unit_tb import dgsl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SLOTS     = 16;
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 12;

  // one display slot as seen on the output channel
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    slot_kind_t         kind;
    logic [CODE_W-1:0]  glyph;
    logic [DIGIT_W-1:0] hi;
    logic [DIGIT_W-1:0] mid;
    logic [DIGIT_W-1:0] lo;
    logic               last;
  } slot_res_t;

  // expected slot layouts, built per accepted amount
  class slot_scoreboard;
    slot_res_t             pending_slots[$];
    logic [SLOT_CNT_W-1:0] slot_count;
    logic [CODE_W-1:0]     currency_code;
    int                    mismatches;

    function new();
      slot_count    = SLOT_COUNT_RST;
      currency_code = CURRENCY_CODE_RST;
      mismatches    = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    // decimal digits, group count, then one entry per slot
    function void note_amount(logic [VALUE_W-1:0] amount);
      logic [DIGIT_W-1:0] dig [20];
      logic [DIGIT_W-1:0] d [3];
      logic [VALUE_W-1:0] rem;
      int unsigned        len, groups, slots, sep, g, pos;
      bit                 fits;
      slot_res_t          r;
      rem = amount;
      len = 0;
      for (int i = 0; i < 20; i++) begin
        dig[i] = DIGIT_W'(rem % 64'd10);
        rem    = rem / 64'd10;
        if (dig[i] != 0) len = i + 1;
      end
      if (len == 0) len = 1;
      groups = (len + GROUP_DIGITS - 1) / GROUP_DIGITS;
      slots  = (slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count;
      fits   = (groups + 1 <= slots);
      sep    = fits ? slots - groups - 1 : 0;
      for (int unsigned j = 0; j < slots; j++) begin
        r       = '0;
        r.idx   = IDX_W'(j);
        r.hi    = BLANK_DIGIT;
        r.mid   = BLANK_DIGIT;
        r.lo    = BLANK_DIGIT;
        r.last  = (j + 1 == slots);
        if (fits && j < sep) begin
          r.kind = KIND_EMPTY;
        end else if (fits && j == sep) begin
          r.kind  = KIND_CURRENCY;
          r.glyph = currency_code;
        end else begin
          r.kind = KIND_GROUP;
          g      = slots - 1 - j;
          for (int k = 0; k < 3; k++) begin
            pos  = g * GROUP_DIGITS + (2 - k);
            d[k] = (pos < len) ? dig[pos] : BLANK_DIGIT;
          end
          r.hi  = d[0];
          r.mid = d[1];
          r.lo  = d[2];
        end
        pending_slots.push_back(r);
      end
    endfunction

    task check_field(string field, logic [IDX_W-1:0] slot, logic [7:0] got,
                     logic [7:0] want);
      if (got !== want)
        report($sformatf("slot %0d %s: got %0d expected %0d", slot, field, got, want));
    endtask

    task check_slot(slot_res_t got);
      slot_res_t want;
      if (pending_slots.size() == 0) begin
        report($sformatf("slot %0d kind %0d arrived with nothing expected",
                         got.idx, got.kind));
      end else begin
        want = pending_slots.pop_front();
        check_field("slot_index", want.idx, 8'(got.idx), 8'(want.idx));
        check_field("slot_kind", want.idx, 8'(got.kind), 8'(want.kind));
        check_field("currency_glyph", want.idx, got.glyph, want.glyph);
        check_field("digit_high", want.idx, 8'(got.hi), 8'(want.hi));
        check_field("digit_mid", want.idx, 8'(got.mid), 8'(want.mid));
        check_field("digit_low", want.idx, 8'(got.lo), 8'(want.lo));
        check_field("last", want.idx, 8'(got.last), 8'(want.last));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dgsl_in_if  in_ch ();
  dgsl_out_if out_ch ();

  slot_scoreboard sb;
  bit             idle_on;
  bit             long_hold_req;
  int             rx_hold;
  int             cycle_count;
  slot_res_t      seen;

  decimal_group_slot_layout_unit #(
    .MAX_SLOTS  (MAX_SLOTS),
    .VALUE_WIDTH(VALUE_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // clock
  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        rx_hold       = LONG_HOLD;
        long_hold_req = 0;
      end else if (rx_hold == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        rx_hold = $urandom_range(1, 4);
      end
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // check every slot transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen.idx   = out_ch.slot_index;
      seen.kind  = slot_kind_t'(out_ch.slot_kind);
      seen.glyph = out_ch.currency_glyph;
      seen.hi    = out_ch.digit_high;
      seen.mid   = out_ch.digit_mid;
      seen.lo    = out_ch.digit_low;
      seen.last  = out_ch.last;
      sb.check_slot(seen);
    end
  end

  // offer one amount, with an optional gap first, and wait for its transfer
  task send_amount(logic [VALUE_W-1:0] amount);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= amount;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_amount(amount);
  endtask

  // both registers, back to back, only while the block is idle
  task set_regs(logic [CFG_DATA_W-1:0] slots, logic [CFG_DATA_W-1:0] code);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    cfg_we      <= 1'b1;
    cfg_index   <= REG_SLOT_COUNT;
    cfg_wdata   <= slots;
    @(negedge clk);
    cfg_index   <= REG_CURRENCY;
    cfg_wdata   <= code;
    @(negedge clk);
    cfg_we      <= 1'b0;
    sb.slot_count    = slots[SLOT_CNT_W-1:0];
    sb.currency_code = code;
  endtask

  // stop offering, all slots in, then room for an amount that yields no slots
  task wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mix of full-width, shortened, near powers of ten and small amounts
  function automatic logic [VALUE_W-1:0] rand_amount();
    logic [VALUE_W-1:0] p;
    case ($urandom_range(0, 3))
      0: rand_amount = {$urandom, $urandom};
      1: rand_amount = {$urandom, $urandom} >> $urandom_range(1, 63);
      2: begin
        p = 1;
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        rand_amount = p + $urandom_range(0, 2) - 1;
      end
      default: rand_amount = VALUE_W'($urandom_range(0, 999999));
    endcase
  endfunction

  task send_list(logic [VALUE_W-1:0] amounts[$]);
    foreach (amounts[i]) send_amount(amounts[i]);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] slots;
    sb            = new();
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_SLOT_COUNT;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    idle_on       = 1;
    long_hold_req = 0;
    rx_hold       = 0;
    cycle_count   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset layout: seven slots, blank currency; digit counts across group borders
    send_list('{64'd0, 64'd1, 64'd12, 64'd999, 64'd1000, 64'd123456, 64'd1000000,
                64'd999999999, 64'd1000000000, 64'd1000000000000000,
                64'd1000000000000000000, '1});
    wait_for_drain();
    // widest layout, top glyph, bit patterns
    set_regs(8'd16, 8'd255);
    send_list('{'1, 64'd0, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
                64'h5555_5555_5555_5555});
    wait_for_drain();
    // single slot: no room for the separator
    set_regs(8'd1, 8'd36);
    send_list('{64'd5, 64'd123456});
    wait_for_drain();
    // two slots: separator just fits ahead of one group
    set_regs(8'd2, 8'd1);
    send_list('{64'd7, 64'd1000});
    wait_for_drain();
    // zero slots: nothing comes out
    set_regs(8'd0, 8'd128);
    send_list('{64'd42, '1});
    wait_for_drain();
    // slot count above the maximum saturates
    set_regs(8'd31, 8'd1);
    send_list('{'1});
    wait_for_drain();

    // random settings per phase; one long result stall, quiet last phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      slots = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(17, 31))
                                          : CFG_DATA_W'($urandom_range(1, 16));
      set_regs(slots, CFG_DATA_W'($urandom_range(0, 255)));
      if (ph == RAND_PHASES - 1) idle_on = 0;
      if (ph == 2) begin
        @(posedge clk);
        long_hold_req = 1;
      end
      repeat (PHASE_ITEMS) send_amount(rand_amount());
      wait_for_drain();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_for_drain();
    if (sb.mismatches == 0 && sb.pending_slots.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/dgsl_pkg.sv
src/dgsl_ifs.sv
src/dgsl_bcd_conv.sv
src/decimal_group_slot_layout_unit.sv
sim/decimal_group_slot_layout_unit_tb.sv
